// ===== rtl/bdd_pkg.sv =====
// Shared types, constants and small lookup functions for the binary decimal decoder.
// No dependencies; every other file in rtl refers to this package by scoped names.
package bdd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LimbW    = 64;
  localparam int unsigned LimbIdxW = 2;
  localparam int unsigned ScaleW   = 7;
  localparam int unsigned WordW    = 32;
  localparam int unsigned MultW    = 30;
  localparam int unsigned CountW   = 6;
  localparam int unsigned GrpW     = 3;
  localparam int unsigned DigW     = 4;

  localparam int unsigned MaxPrecision      = 65;
  localparam int unsigned ValueLimbsDefault = 4;
  localparam int unsigned CmdDepthDefault   = 4;
  localparam int unsigned OutDepthDefault   = 2;

  localparam logic [MultW-1:0] GroupRadix = 30'd1000000000;
  localparam logic [ByteW-1:0] SignBit    = 8'h80;
  localparam logic [GrpW-1:0]  FullGroup  = 3'd4;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StBadGroup  = 2'd1,
    StBadHeader = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PhPrec,
    PhScale,
    PhBody
  } phase_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkMac,
    BkEmit
  } back_state_e;

  // One word from the parser to the arithmetic unit.
  typedef struct packed {
    logic              do_mac;
    logic              do_emit;
    logic [MultW-1:0]  mult;
    logic [WordW-1:0]  word;
    status_e           status;
    logic [ScaleW-1:0] scale;
    logic              neg;
  } cmd_t;

  typedef struct packed {
    logic [LimbW-1:0]    limb;
    logic [LimbIdxW-1:0] limb_index;
    logic [ScaleW-1:0]   scale;
    status_e             status;
    logic                last;
  } res_t;

  // Bytes taken by a partial group of the given digit count.
  function automatic logic [GrpW-1:0] group_len(input logic [DigW-1:0] digits);
    logic [GrpW-1:0] len;
    case (digits)
      4'd0:    len = 3'd0;
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd1;
      4'd3:    len = 3'd2;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd3;
      4'd6:    len = 3'd3;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [MultW-1:0] pow10(input logic [DigW-1:0] digits);
    logic [MultW-1:0] p;
    case (digits)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = GroupRadix;
    endcase
    return p;
  endfunction

  // Quotient by nine through a reciprocal multiply; exact for every 7-bit value.
  function automatic logic [DigW-1:0] div9(input logic [ScaleW-1:0] v);
    logic [12:0] p;
    p = 13'(v) * 13'd57;
    return p[12:9];
  endfunction

  function automatic logic [DigW-1:0] mod9(input logic [ScaleW-1:0] v);
    logic [ScaleW-1:0] r;
    r = v - ScaleW'(div9(v)) * 7'd9;
    return r[DigW-1:0];
  endfunction

endpackage

// ===== rtl/bdd_fifo.sv =====
// Small first-in first-out buffer of register entries, used between the decoder stages.
// Depends on bdd_pkg for its default depth.
module bdd_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = bdd_pkg::OutDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr_en, rd_en;

  assign full_o  = (count_q == DepthCnt);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/bdd_front.sv =====
// Byte parser: header checks, body layout, sign handling and group assembly.
// Depends on bdd_pkg; emits one command word per byte that completes a group or a decimal.
module bdd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [bdd_pkg::ByteW-1:0]  data_byte_i,
  output logic                       cmd_push_o,
  output bdd_pkg::cmd_t              cmd_o
);

  bdd_pkg::phase_e  phase_q, phase_d;
  bdd_pkg::status_e err_q, err_d;
  logic [bdd_pkg::ScaleW-1:0] prec_q, prec_d, scale_q, scale_d;
  logic [bdd_pkg::CountW-1:0] total_q, total_d, bytes_left_q, bytes_left_d;
  logic [bdd_pkg::GrpW-1:0]   grp_left_q, grp_left_d;
  logic [bdd_pkg::WordW-1:0]  group_word_q, group_word_d;
  logic [bdd_pkg::DigW-1:0]   lead_q, lead_d, trail_q, trail_d;
  logic                       neg_q, neg_d;

  // Header and layout.
  logic                       hdr_bad, prec_bad;
  logic [bdd_pkg::ScaleW-1:0] scale_v, diff_v;
  logic [bdd_pkg::DigW-1:0]   lead_v, trail_v;
  logic [4:0]                 qsum;
  logic [7:0]                 tot_w;
  logic [bdd_pkg::CountW-1:0] layout_total;

  // Body byte.
  logic                       first, neg_new, grp_start, grp_done, body_fin;
  logic                       is_lead, is_trail, is_full, group_bad;
  logic [bdd_pkg::ByteW-1:0]  body_byte;
  logic [bdd_pkg::GrpW-1:0]   len_start, grp_base, grp_left_new, len_end;
  logic [bdd_pkg::WordW-1:0]  gw_base, gw_new, word_ext;
  logic [bdd_pkg::CountW-1:0] bl_new, consumed;
  logic [bdd_pkg::MultW-1:0]  mult_end;
  bdd_pkg::status_e           err_new;
  logic                       clear_dec;

  assign prec_bad = (data_byte_i == '0) ||
                    (data_byte_i > bdd_pkg::ByteW'(bdd_pkg::MaxPrecision));
  assign hdr_bad  = (err_q == bdd_pkg::StBadHeader) || (data_byte_i > {1'b0, prec_q});

  assign scale_v = data_byte_i[bdd_pkg::ScaleW-1:0];
  assign diff_v  = prec_q - scale_v;
  assign lead_v  = bdd_pkg::mod9(diff_v);
  assign trail_v = bdd_pkg::mod9(scale_v);
  assign qsum    = 5'(bdd_pkg::div9(diff_v)) + 5'(bdd_pkg::div9(scale_v));
  assign tot_w   = {1'b0, qsum, 2'b00} + 8'(bdd_pkg::group_len(lead_v))
                   + 8'(bdd_pkg::group_len(trail_v));
  assign layout_total = tot_w[bdd_pkg::CountW-1:0];

  // The sign bit is flipped on the first body byte; negative values arrive complemented.
  assign first     = (bytes_left_q == total_q);
  assign neg_new   = first ? !data_byte_i[bdd_pkg::ByteW-1] : neg_q;
  assign body_byte = data_byte_i ^ (first ? bdd_pkg::SignBit : '0)
                     ^ {bdd_pkg::ByteW{neg_new}};

  always_comb begin
    if (first && lead_q != '0) begin
      len_start = bdd_pkg::group_len(lead_q);
    end else if (trail_q != '0 &&
                 bytes_left_q == bdd_pkg::CountW'(bdd_pkg::group_len(trail_q))) begin
      len_start = bdd_pkg::group_len(trail_q);
    end else begin
      len_start = bdd_pkg::FullGroup;
    end
  end

  assign grp_start    = (grp_left_q == '0);
  assign grp_base     = grp_start ? len_start : grp_left_q;
  assign gw_base      = grp_start ? '0 : group_word_q;
  assign gw_new       = {gw_base[bdd_pkg::WordW-bdd_pkg::ByteW-1:0], body_byte};
  assign grp_left_new = grp_base - 1'b1;
  assign bl_new       = bytes_left_q - 1'b1;
  assign grp_done     = (grp_left_new == '0);
  assign body_fin     = (bl_new == '0);
  assign consumed     = total_q - bl_new;

  assign is_lead  = (lead_q != '0) &&
                    (consumed == bdd_pkg::CountW'(bdd_pkg::group_len(lead_q)));
  assign is_trail = !is_lead && (trail_q != '0) && body_fin;
  assign is_full  = !is_lead && !is_trail;

  always_comb begin
    if (is_lead) begin
      len_end  = bdd_pkg::group_len(lead_q);
      mult_end = bdd_pkg::MultW'(1);
    end else if (is_trail) begin
      len_end  = bdd_pkg::group_len(trail_q);
      mult_end = bdd_pkg::pow10(trail_q);
    end else begin
      len_end  = bdd_pkg::FullGroup;
      mult_end = bdd_pkg::GroupRadix;
    end
  end

  // Partial groups are sign-extended from their own length.
  always_comb begin
    case (len_end)
      3'd1:    word_ext = {{24{gw_new[7]}}, gw_new[7:0]};
      3'd2:    word_ext = {{16{gw_new[15]}}, gw_new[15:0]};
      3'd3:    word_ext = {{8{gw_new[23]}}, gw_new[23:0]};
      default: word_ext = gw_new;
    endcase
  end

  assign group_bad = grp_done && is_full &&
                     (word_ext >= bdd_pkg::WordW'(bdd_pkg::GroupRadix));
  assign err_new   = (group_bad && err_q == bdd_pkg::StOk) ? bdd_pkg::StBadGroup : err_q;

  // Phase sequencing.
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (phase_q)
        bdd_pkg::PhScale: begin
          if (hdr_bad || layout_total == '0) begin
            phase_d = bdd_pkg::PhPrec;
          end else begin
            phase_d = bdd_pkg::PhBody;
          end
        end
        bdd_pkg::PhBody: begin
          if (body_fin) begin
            phase_d = bdd_pkg::PhPrec;
          end
        end
        default: phase_d = bdd_pkg::PhScale;
      endcase
    end
  end

  // Command word toward the arithmetic unit.
  always_comb begin
    cmd_o      = '0;
    cmd_push_o = 1'b0;
    if (phase_q == bdd_pkg::PhScale) begin
      cmd_o.do_emit = 1'b1;
      cmd_o.status  = bdd_pkg::StBadHeader;
      cmd_push_o    = accept_i && hdr_bad;
    end else begin
      cmd_o.do_mac  = grp_done;
      cmd_o.do_emit = body_fin;
      cmd_o.mult    = mult_end;
      cmd_o.word    = word_ext;
      cmd_o.status  = err_new;
      cmd_o.scale   = scale_q;
      cmd_o.neg     = neg_new;
      cmd_push_o    = accept_i && (phase_q == bdd_pkg::PhBody) && (grp_done || body_fin);
    end
  end

  // Parser registers.
  always_comb begin
    err_d        = err_q;
    prec_d       = prec_q;
    scale_d      = scale_q;
    total_d      = total_q;
    bytes_left_d = bytes_left_q;
    grp_left_d   = grp_left_q;
    group_word_d = group_word_q;
    lead_d       = lead_q;
    trail_d      = trail_q;
    neg_d        = neg_q;
    clear_dec    = 1'b0;
    if (accept_i) begin
      case (phase_q)
        bdd_pkg::PhScale: begin
          if (hdr_bad) begin
            clear_dec = 1'b1;
          end else begin
            scale_d      = scale_v;
            lead_d       = lead_v;
            trail_d      = trail_v;
            total_d      = layout_total;
            bytes_left_d = layout_total;
            grp_left_d   = '0;
            group_word_d = '0;
            neg_d        = 1'b0;
          end
        end
        bdd_pkg::PhBody: begin
          if (body_fin) begin
            clear_dec = 1'b1;
          end else begin
            neg_d        = neg_new;
            group_word_d = gw_new;
            grp_left_d   = grp_left_new;
            bytes_left_d = bl_new;
            err_d        = err_new;
          end
        end
        default: begin
          if (prec_bad) begin
            err_d  = bdd_pkg::StBadHeader;
            prec_d = '0;
          end else begin
            err_d  = bdd_pkg::StOk;
            prec_d = scale_v;
          end
        end
      endcase
    end
    if (clear_dec) begin
      err_d        = bdd_pkg::StOk;
      prec_d       = '0;
      scale_d      = '0;
      total_d      = '0;
      bytes_left_d = '0;
      grp_left_d   = '0;
      group_word_d = '0;
      lead_d       = '0;
      trail_d      = '0;
      neg_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= bdd_pkg::PhPrec;
      err_q        <= bdd_pkg::StOk;
      prec_q       <= '0;
      scale_q      <= '0;
      total_q      <= '0;
      bytes_left_q <= '0;
      grp_left_q   <= '0;
      group_word_q <= '0;
      lead_q       <= '0;
      trail_q      <= '0;
      neg_q        <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      err_q        <= err_d;
      prec_q       <= prec_d;
      scale_q      <= scale_d;
      total_q      <= total_d;
      bytes_left_q <= bytes_left_d;
      grp_left_q   <= grp_left_d;
      group_word_q <= group_word_d;
      lead_q       <= lead_d;
      trail_q      <= trail_d;
      neg_q        <= neg_d;
    end
  end

endmodule

// ===== rtl/bdd_back.sv =====
// Arithmetic unit: multiply-accumulate into the wide value, one 32-bit slice per cycle,
// then limb output with optional negation. Depends on bdd_pkg for the command and result words.
module bdd_back #(
  parameter int unsigned ValueLimbs = bdd_pkg::ValueLimbsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  bdd_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          out_full_i,
  output logic          out_push_o,
  output bdd_pkg::res_t res_o
);

  localparam int unsigned AccW  = ValueLimbs * bdd_pkg::LimbW;
  localparam int unsigned StepW = $clog2(2 * ValueLimbs);
  localparam logic [StepW-1:0] MacLast  = StepW'(2 * ValueLimbs - 1);
  localparam logic [StepW-1:0] EmitLast = StepW'(ValueLimbs - 1);

  bdd_pkg::back_state_e state_q, state_d, cmd_state;
  bdd_pkg::status_e     status_q, status_d;
  logic [StepW-1:0]                step_q, step_d;
  logic [AccW-1:0]                 acc_q, acc_d;
  logic [bdd_pkg::WordW-1:0]       carry_q, carry_d;
  logic [bdd_pkg::MultW-1:0]       mult_q, mult_d;
  logic [bdd_pkg::ScaleW-1:0]      scale_q, scale_d;
  logic                            do_emit_q, do_emit_d, neg_q, neg_d, ncarry_q, ncarry_d;

  logic                            mac_last, emit_last, emit_go, take;
  logic [61:0]                     prod;
  logic [62:0]                     mac_sum;
  logic [bdd_pkg::LimbW-1:0]       neg_limb, limb_val;

  assign mac_last  = (step_q == MacLast);
  assign emit_last = (step_q == EmitLast);
  assign emit_go   = (state_q == bdd_pkg::BkEmit) && !out_full_i;
  assign take      = cmd_valid_i &&
                     ((state_q == bdd_pkg::BkIdle) ||
                      (state_q == bdd_pkg::BkMac && mac_last && !do_emit_q) ||
                      (emit_go && emit_last));
  assign cmd_state = cmd_i.do_mac  ? bdd_pkg::BkMac  :
                     cmd_i.do_emit ? bdd_pkg::BkEmit : bdd_pkg::BkIdle;

  // Low slice times the multiplier plus the running carry; the first carry is the group word.
  assign prod     = 62'(acc_q[bdd_pkg::WordW-1:0]) * 62'(mult_q);
  assign mac_sum  = {1'b0, prod} + 63'(carry_q);
  assign neg_limb = ~acc_q[bdd_pkg::LimbW-1:0] + bdd_pkg::LimbW'(ncarry_q);
  assign limb_val = neg_q ? neg_limb : acc_q[bdd_pkg::LimbW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      bdd_pkg::BkIdle: begin
        if (take) begin
          state_d = cmd_state;
        end
      end
      bdd_pkg::BkMac: begin
        if (mac_last) begin
          if (do_emit_q) begin
            state_d = bdd_pkg::BkEmit;
          end else if (take) begin
            state_d = cmd_state;
          end else begin
            state_d = bdd_pkg::BkIdle;
          end
        end
      end
      bdd_pkg::BkEmit: begin
        if (emit_go && emit_last) begin
          state_d = take ? cmd_state : bdd_pkg::BkIdle;
        end
      end
      default: state_d = bdd_pkg::BkIdle;
    endcase
  end

  always_comb begin
    cmd_pop_o        = take;
    out_push_o       = emit_go;
    res_o.limb       = (status_q == bdd_pkg::StOk) ? limb_val : '0;
    res_o.limb_index = bdd_pkg::LimbIdxW'(step_q);
    res_o.scale      = scale_q;
    res_o.status     = status_q;
    res_o.last       = emit_last;
  end

  always_comb begin
    step_d    = step_q;
    acc_d     = acc_q;
    carry_d   = carry_q;
    mult_d    = mult_q;
    do_emit_d = do_emit_q;
    status_d  = status_q;
    scale_d   = scale_q;
    neg_d     = neg_q;
    ncarry_d  = ncarry_q;
    if (state_q == bdd_pkg::BkMac) begin
      // The value rotates down one slice per step and is back in place after the last one.
      acc_d   = {mac_sum[bdd_pkg::WordW-1:0], acc_q[AccW-1:bdd_pkg::WordW]};
      carry_d = {1'b0, mac_sum[62:bdd_pkg::WordW]};
      step_d  = mac_last ? '0 : step_q + 1'b1;
    end
    if (emit_go) begin
      // Shifting zeros in leaves the value cleared for the next decimal.
      acc_d    = AccW'(acc_q >> bdd_pkg::LimbW);
      ncarry_d = ncarry_q && (neg_limb == '0);
      step_d   = emit_last ? '0 : step_q + 1'b1;
    end
    if (take) begin
      mult_d    = cmd_i.mult;
      carry_d   = cmd_i.word;
      do_emit_d = cmd_i.do_emit;
      status_d  = cmd_i.status;
      scale_d   = cmd_i.scale;
      neg_d     = cmd_i.neg;
      ncarry_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bdd_pkg::BkIdle;
      step_q    <= '0;
      acc_q     <= '0;
      do_emit_q <= 1'b0;
      ncarry_q  <= 1'b1;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      acc_q     <= acc_d;
      do_emit_q <= do_emit_d;
      ncarry_q  <= ncarry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q  <= carry_d;
    mult_q   <= mult_d;
    status_q <= status_d;
    scale_q  <= scale_d;
    neg_q    <= neg_d;
  end

endmodule

// ===== rtl/binary_decimal_decode_top.sv =====
// Top level of the binary decimal decoder: parser, command queue, arithmetic unit, result queue.
// Depends on bdd_pkg, bdd_front, bdd_fifo and bdd_back.
//
//   channel   direction  handshake            payload
//   bytes     in         push / full          data_byte_i
//   results   out        empty / pop          limb_o, limb_index_o, scale_out_o, status_o, last_o
//
// The parser takes one byte per cycle while the command queue has room.
// Each completed group is multiplied into the value in the arithmetic unit (one 32x30 multiply
// per cycle); each decimal then writes its limbs, one per cycle while the result queue has room.
// Reset is asynchronous and active low; the block is ready as soon as reset is released.
// A stalled result queue backs up into the command queue and then raises full.
module binary_decimal_decode_top #(
  parameter int unsigned ValueLimbs = bdd_pkg::ValueLimbsDefault,
  parameter int unsigned CmdDepth   = bdd_pkg::CmdDepthDefault,
  parameter int unsigned OutDepth   = bdd_pkg::OutDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [bdd_pkg::ByteW-1:0]     data_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [bdd_pkg::LimbW-1:0]     limb_o,
  output logic [bdd_pkg::LimbIdxW-1:0]  limb_index_o,
  output logic [bdd_pkg::ScaleW-1:0]    scale_out_o,
  output logic [1:0]                    status_o,
  output logic                          last_o
);

  localparam int unsigned CmdW = $bits(bdd_pkg::cmd_t);
  localparam int unsigned ResW = $bits(bdd_pkg::res_t);

  bdd_pkg::cmd_t front_cmd, back_cmd;
  bdd_pkg::res_t back_res, out_res;
  logic          accept, cmd_push, cmd_valid, cmd_pop;
  logic          out_push, out_full, out_valid;
  logic [CmdW-1:0] cmd_rdata;
  logic [ResW-1:0] out_rdata;

  assign accept   = push && !full;
  assign back_cmd = cmd_rdata;
  assign out_res  = out_rdata;

  bdd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (front_cmd)
  );

  bdd_fifo #(
    .Width (CmdW),
    .Depth (CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .valid_o (cmd_valid)
  );

  bdd_back #(
    .ValueLimbs (ValueLimbs)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .res_o       (back_res)
  );

  bdd_fifo #(
    .Width (ResW),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .valid_o (out_valid)
  );

  assign empty        = !out_valid;
  assign limb_o       = out_res.limb;
  assign limb_index_o = out_res.limb_index;
  assign scale_out_o  = out_res.scale;
  assign status_o     = out_res.status;
  assign last_o       = out_res.last;

  // A decimal with an error status never shows a value.
  a_err_limb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != bdd_pkg::StOk) |-> (limb_o == '0))
    else $error("limb is nonzero on a word with an error status");

  // A rejected header reports no scale.
  a_hdr_scale_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == bdd_pkg::StBadHeader) |-> (scale_out_o == '0))
    else $error("scale is nonzero on a word with a header error");

  // The last marker sits on the most significant limb and nowhere else.
  a_last_on_top_limb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == (limb_index_o == bdd_pkg::LimbIdxW'(ValueLimbs - 1))))
    else $error("last marker does not match the limb index");

  // The arithmetic unit only takes a command that the queue holds.
  a_cmd_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty queue");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for binary_decimal_decode_top: streams encoded decimals and checks each limb.
// Depends on bdd_pkg and the decoder RTL; an in-bench decoder model predicts every result word.
module tb;
  import bdd_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned LatencyTail = 64;
  localparam int unsigned StreamBytes = 120;

  typedef enum logic [1:0] {
    BodyDigits,
    BodyMax,
    BodyNoise
  } body_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [ByteW-1:0]    data_byte_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [LimbW-1:0]    limb_o;
  logic [LimbIdxW-1:0] limb_index_o;
  logic [ScaleW-1:0]   scale_out_o;
  logic [1:0]          status_o;
  logic                last_o;

  binary_decimal_decode_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .empty       (empty),
    .pop         (pop),
    .limb_o      (limb_o),
    .limb_index_o(limb_index_o),
    .scale_out_o (scale_out_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [ByteW-1:0] stream_q[$];
  res_t             limb_q[$];
  int unsigned      stream_len = 0;
  int unsigned      bytes_in = 0;
  int unsigned      limbs_checked = 0;
  int unsigned      n_fail = 0;
  int unsigned      n_decimals = 0;
  int unsigned      n_bad_header = 0;
  int unsigned      n_bad_group = 0;
  int unsigned      n_negative = 0;
  int unsigned      idle_cycles = 0;

  // Decoder model state.
  phase_e          dec_phase = PhPrec;
  logic [6:0]      dec_prec = '0;
  logic [6:0]      dec_scale = '0;
  logic [5:0]      dec_left = '0;
  logic [2:0]      dec_grp_left = '0;
  logic [31:0]     dec_grp_word = '0;
  logic            dec_neg = 1'b0;
  logic [255:0]    dec_acc = '0;
  status_e         dec_err = StOk;

  // Bytes used by a group of the given digit count: two digits per byte, at most four bytes.
  function automatic int unsigned partial_bytes(input int unsigned digits);
    int unsigned n;
    n = (digits + 1) / 2;
    return (n > 4) ? 4 : n;
  endfunction

  function automatic logic [31:0] ten_to(input int unsigned digits);
    logic [31:0] p;
    p = 32'd1;
    for (int unsigned i = 0; i < digits; i++) p = p * 32'd10;
    return p;
  endfunction

  function automatic int unsigned body_bytes(input int unsigned p, input int unsigned s);
    int unsigned d;
    d = (p >= s) ? p - s : 0;
    return 4 * (d / 9 + s / 9) + partial_bytes(d % 9) + partial_bytes(s % 9);
  endfunction

  task automatic restart_decimal();
    dec_phase    = PhPrec;
    dec_prec     = '0;
    dec_scale    = '0;
    dec_left     = '0;
    dec_grp_left = '0;
    dec_grp_word = '0;
    dec_neg      = 1'b0;
    dec_acc      = '0;
    dec_err      = StOk;
  endtask

  task automatic post_limbs(input status_e st, input logic [6:0] sc);
    res_t r;
    for (int k = 0; k < 4; k++) begin
      r.limb       = (st == StOk) ? dec_acc[64*k +: 64] : '0;
      r.limb_index = k[1:0];
      r.scale      = sc;
      r.status     = st;
      r.last       = (k == 3);
      limb_q.insert(limb_q.size(), r);
    end
    n_decimals++;
    if (st == StBadHeader) n_bad_header++;
    if (st == StBadGroup) n_bad_group++;
  endtask

  // Advances the decoder model by one accepted byte and queues the limbs it completes.
  task automatic decode_byte(input logic [7:0] din);
    logic [7:0]  b;
    logic [31:0] word;
    logic [31:0] lim;
    logic [31:0] mult;
    int unsigned d;
    int unsigned lead;
    int unsigned trail;
    int unsigned total;
    int unsigned len;
    int unsigned consumed;
    logic        first;
    logic        full_grp;
    b = din;
    if (dec_phase == PhScale) begin
      if (dec_err == StBadHeader || b > {1'b0, dec_prec}) begin
        post_limbs(StBadHeader, '0);
        restart_decimal();
      end else begin
        dec_scale    = b[6:0];
        total        = body_bytes(dec_prec, dec_scale);
        dec_left     = total[5:0];
        dec_grp_left = '0;
        dec_grp_word = '0;
        dec_neg      = 1'b0;
        dec_acc      = '0;
        dec_phase    = (dec_left == 0) ? PhPrec : PhBody;
      end
    end else if (dec_phase != PhBody) begin
      if (b == 0 || b > MaxPrecision) begin
        dec_err  = StBadHeader;
        dec_prec = '0;
      end else begin
        dec_err  = StOk;
        dec_prec = b[6:0];
      end
      dec_phase = PhScale;
    end else begin
      d     = (dec_prec >= dec_scale) ? dec_prec - dec_scale : 0;
      lead  = d % 9;
      trail = dec_scale % 9;
      total = body_bytes(dec_prec, dec_scale);
      first = (dec_left == total);
      if (first) begin
        dec_neg = ~b[7];
        b       = b ^ SignBit;
      end
      if (dec_neg) b = ~b;
      if (dec_grp_left == 0) begin
        len = 4;
        if (first && lead > 0) len = partial_bytes(lead);
        else if (trail > 0 && dec_left == partial_bytes(trail)) len = partial_bytes(trail);
        dec_grp_left = len[2:0];
        dec_grp_word = '0;
      end
      dec_grp_word = {dec_grp_word[23:0], b};
      dec_grp_left = dec_grp_left - 3'd1;
      dec_left     = dec_left - 6'd1;
      if (dec_grp_left == 0) begin
        consumed = total - dec_left;
        len      = 4;
        mult     = ten_to(9);
        word     = dec_grp_word;
        full_grp = 1'b0;
        if (lead > 0 && consumed == partial_bytes(lead)) begin
          len  = partial_bytes(lead);
          mult = 32'd1;
        end else if (trail > 0 && dec_left == 0) begin
          len  = partial_bytes(trail);
          mult = ten_to(trail);
        end else begin
          full_grp = 1'b1;
        end
        // Partial groups are sign-extended from their own width.
        if (len < 4) begin
          lim  = 32'd1 << (8 * len);
          word = word & (lim - 32'd1);
          if ((word & (lim >> 1)) != 0) word = word | ~(lim - 32'd1);
        end
        if (full_grp && word >= ten_to(9) && dec_err == StOk) dec_err = StBadGroup;
        dec_acc = dec_acc * mult + word;
      end
      if (dec_left == 0) begin
        if (dec_neg) begin
          dec_acc = -dec_acc;
          n_negative++;
        end
        post_limbs(dec_err, dec_scale);
        restart_decimal();
      end
    end
  endtask

  // Appends one decimal to the stream: header, then, if the header is valid, a body sized from it.
  task automatic queue_decimal(input logic [7:0] p, input logic [7:0] s, input body_e shape,
                               input bit neg);
    logic [7:0]  body[$];
    int unsigned digits[$];
    int unsigned d;
    int unsigned total;
    int unsigned len;
    logic [31:0] val;
    stream_q.insert(stream_q.size(), p);
    stream_q.insert(stream_q.size(), s);
    if (p == 0 || p > MaxPrecision || s > p) return;
    d     = p - s;
    total = body_bytes(p, s);
    if (shape == BodyNoise) begin
      for (int unsigned i = 0; i < total; i++)
        body.insert(body.size(), 8'($urandom_range(0, 255)));
    end else begin
      if (d % 9 > 0) digits.insert(digits.size(), d % 9);
      for (int unsigned g = 0; g < d / 9 + s / 9; g++) digits.insert(digits.size(), 9);
      if (s % 9 > 0) digits.insert(digits.size(), s % 9);
      foreach (digits[g]) begin
        len = partial_bytes(digits[g]);
        val = (shape == BodyMax) ? ten_to(digits[g]) - 32'd1 : $urandom % ten_to(digits[g]);
        for (int unsigned k = len; k > 0; k--) body.insert(body.size(), val[8*(k-1) +: 8]);
      end
      if (neg) foreach (body[i]) body[i] = ~body[i];
      body[0] = body[0] ^ SignBit;
    end
    foreach (body[i]) stream_q.insert(stream_q.size(), body[i]);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push        <= 1'b0;
      data_byte_i <= '0;
    end else begin
      if (push && !full) begin
        decode_byte(data_byte_i);
        bytes_in++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (stream_q.size() > 0) begin
          push        <= 1'b1;
          data_byte_i <= stream_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 2) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 30 : 5);
          end else begin
            burst_left--;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: pop follows a rotating pattern that is redrawn each time stall_age reaches its top value.
  logic [15:0] stall_pat = '1;
  logic [5:0]  stall_age = '0;

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      pop       <= 1'b0;
      stall_pat <= '1;
      stall_age <= '0;
    end else begin
      if (pop && !empty) begin
        if (limb_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("Unexpected result word: limb=%h index=%0d scale=%0d status=%0d last=%0d",
                     limb_o, limb_index_o, scale_out_o, status_o, last_o);
        end else begin
          want = limb_q.pop_front();
          limbs_checked++;
          if (limb_o !== want.limb || limb_index_o !== want.limb_index ||
              scale_out_o !== want.scale || status_o !== 2'(want.status) ||
              last_o !== want.last) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display({"Mismatch on word %0d: expected limb=%h index=%0d scale=%0d",
                        " status=%0d last=%0d"},
                       limbs_checked, want.limb, want.limb_index, want.scale,
                       2'(want.status), want.last);
              $display("  got limb=%h index=%0d scale=%0d status=%0d last=%0d",
                       limb_o, limb_index_o, scale_out_o, status_o, last_o);
            end
          end
        end
      end
      pop <= stall_pat[0];
      if (stall_age == 6'd63) begin
        case ($urandom_range(0, 3))
          0:       stall_pat <= '1;
          1:       stall_pat <= 16'($urandom);
          2:       stall_pat <= 16'($urandom | $urandom);
          default: stall_pat <= 16'($urandom & $urandom);
        endcase
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
      stall_age <= stall_age + 6'd1;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int unsigned r;
    int unsigned p;
    int unsigned s;
    body_e       shape;

    // Directed: smallest decimals of both signs, each kind of bad header, a group of 1e9 or
    // more, and a full group followed by a one-digit fraction at its largest digits.
    queue_decimal(8'd1, 8'd0, BodyMax, 1'b0);
    queue_decimal(8'd1, 8'd1, BodyMax, 1'b1);
    queue_decimal(8'd0, 8'd0, BodyDigits, 1'b0);
    queue_decimal(8'd66, 8'd5, BodyDigits, 1'b0);
    queue_decimal(8'd2, 8'd3, BodyDigits, 1'b0);
    stream_q.insert(stream_q.size(), 8'd9);
    stream_q.insert(stream_q.size(), 8'd0);
    repeat (4) stream_q.insert(stream_q.size(), 8'hFF);
    queue_decimal(8'd10, 8'd1, BodyMax, 1'b0);

    while (stream_q.size() < StreamBytes) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        p = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(66, 255);
        s = $urandom_range(0, 255);
      end else if (r < 12) begin
        p = $urandom_range(1, 64);
        s = $urandom_range(p + 1, 255);
      end else begin
        if (r < 16) p = MaxPrecision;
        else if (r < 28) p = $urandom_range(21, MaxPrecision);
        else p = $urandom_range(1, 20);
        s = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : p)
                                        : $urandom_range(0, p);
      end
      r = $urandom_range(0, 99);
      if (r < 20) shape = BodyNoise;
      else if (r < 28) shape = BodyMax;
      else shape = BodyDigits;
      queue_decimal(8'(p), 8'(s), shape, 1'($urandom));
    end
    stream_len = stream_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(bytes_in == stream_len && limb_q.size() == 0) && idle_cycles < IdleLimit)
      @(posedge clk_i);
    if (idle_cycles >= IdleLimit) begin
      $display("Timed out with %0d of %0d bytes sent and %0d words outstanding",
               bytes_in, stream_len, limb_q.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      repeat (LatencyTail) @(posedge clk_i);
      $display("Sent %0d bytes forming %0d decimals: %0d negative, %0d bad headers,",
               bytes_in, n_decimals, n_negative, n_bad_header);
      $display("%0d bad groups; checked %0d result words, %0d failures.",
               n_bad_group, limbs_checked, n_fail);
      if (n_fail == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/bdd_pkg.sv
rtl/bdd_fifo.sv
rtl/bdd_front.sv
rtl/bdd_back.sv
rtl/binary_decimal_decode_top.sv
bench/tb.sv
